/* hw/rtl/mhpq_pkg.sv */
package mhpq_pkg;

  localparam int SLOTS   = 16;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // ram read address source
  typedef enum logic [2:0] {
    RA_ROOT,
    RA_LAST,
    RA_PARENT,
    RA_LEFT,
    RA_RIGHT
  } rd_sel_t;

  // ram write data source
  typedef enum logic [1:0] {
    WD_V,
    WD_RD,
    WD_BEST
  } wr_sel_t;

  // position register source
  typedef enum logic [2:0] {
    PS_INS,
    PS_ROOT,
    PS_PARENT,
    PS_LEFT,
    PS_BEST
  } pos_sel_t;

  typedef struct packed {
    logic     load_ins;
    logic     set_fail;
    logic     ld_removed;
    logic     ld_last;
    logic     ld_lval;
    logic     ld_out;
    logic     pos_ld;
    pos_sel_t pos_sel;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic has_left;
    logic has_right;
    logic rd_gt_v;
    logic v_gt_rd;
    logic rd_gt_l;
    logic l_gt_v;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/mhpq_ram.sv */
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mhpq_dp.sv */
module mhpq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mhpq_pkg::cmd_t                       cmd,
  output mhpq_pkg::sts_t                       sts,
  input  logic signed [mhpq_pkg::DATA_W-1:0]   value,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 ok,
  output logic signed [mhpq_pkg::DATA_W-1:0]   removed_value,
  output logic signed [mhpq_pkg::DATA_W-1:0]   top_value,
  output logic [mhpq_pkg::COUNT_W-1:0]         count,
  output logic                                 is_empty
);
  import mhpq_pkg::*;

  logic [ADDR_W-1:0]        cnt;
  logic [ADDR_W-1:0]        pos;
  logic signed [DATA_W-1:0] v;
  logic signed [DATA_W-1:0] lval;
  logic signed [DATA_W-1:0] removed;
  logic                     ok_w;

  logic signed [DATA_W-1:0] rd;
  logic [ADDR_W-1:0]        raddr;
  logic signed [DATA_W-1:0] wdata;
  logic [ADDR_W:0]          left;
  logic [ADDR_W:0]          right;
  logic [ADDR_W-1:0]        pos_next;
  logic [ADDR_W-1:0]        best_idx;
  logic signed [DATA_W-1:0] best_val;

  assign left  = {pos, 1'b0};
  assign right = {pos, 1'b1};

  // right child wins only on strictly greater
  assign best_val = sts.rd_gt_l ? rd : lval;
  assign best_idx = sts.rd_gt_l ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

  assign sts.full      = (cnt == ADDR_W'(SLOTS - 1));
  assign sts.empty     = (cnt == '0);
  assign sts.pos_root  = (pos == ADDR_W'(1));
  assign sts.has_left  = (left <= {1'b0, cnt});
  assign sts.has_right = (right <= {1'b0, cnt});
  assign sts.rd_gt_v   = (rd > v);
  assign sts.v_gt_rd   = (v > rd);
  assign sts.rd_gt_l   = (rd > lval);
  assign sts.l_gt_v    = (lval > v);
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    unique case (cmd.rd_sel)
      RA_ROOT:   raddr = ADDR_W'(1);
      RA_LAST:   raddr = cnt;
      RA_PARENT: raddr = pos >> 1;
      RA_LEFT:   raddr = left[ADDR_W-1:0];
      RA_RIGHT:  raddr = right[ADDR_W-1:0];
      default:   raddr = ADDR_W'(1);
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WD_V:    wdata = v;
      WD_RD:   wdata = rd;
      WD_BEST: wdata = best_val;
      default: wdata = v;
    endcase
  end

  always_comb begin
    unique case (cmd.pos_sel)
      PS_INS:    pos_next = cnt + ADDR_W'(1);
      PS_ROOT:   pos_next = ADDR_W'(1);
      PS_PARENT: pos_next = pos >> 1;
      PS_LEFT:   pos_next = left[ADDR_W-1:0];
      PS_BEST:   pos_next = best_idx;
      default:   pos_next = pos;
    endcase
  end

  mhpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(pos),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_ins) begin
        cnt <= cnt + ADDR_W'(1);
      end else if (cmd.ld_last) begin
        cnt <= cnt - ADDR_W'(1);
      end
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_ld) begin
      pos <= pos_next;
    end
    if (cmd.load_ins) begin
      v <= value;
    end else if (cmd.ld_last) begin
      v <= rd;
    end
    if (cmd.ld_lval) begin
      lval <= rd;
    end
    if (cmd.load_ins) begin
      ok_w    <= 1'b1;
      removed <= '1;
    end else if (cmd.set_fail) begin
      ok_w    <= 1'b0;
      removed <= '1;
    end else if (cmd.ld_removed) begin
      ok_w    <= 1'b1;
      removed <= rd;
    end
    if (cmd.ld_out) begin
      ok            <= ok_w;
      removed_value <= removed;
      top_value     <= sts.empty ? '1 : rd;
      count         <= COUNT_W'(cnt);
      is_empty      <= sts.empty;
    end
  end

endmodule

/* hw/rtl/mhpq_ctrl.sv */
module mhpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           opcode,
  input  mhpq_pkg::sts_t sts,
  output mhpq_pkg::cmd_t cmd
);
  import mhpq_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_RM_ROOT  = 10'b0000000010,
    ST_RM_LAST  = 10'b0000000100,
    ST_UP       = 10'b0000001000,
    ST_UP_CMP   = 10'b0000010000,
    ST_DN       = 10'b0000100000,
    ST_DN_LEFT  = 10'b0001000000,
    ST_DN_RIGHT = 10'b0010000000,
    ST_TOP_RD   = 10'b0100000000,
    ST_TOP      = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_ROOT;
    cmd.wr_sel = WD_V;
    cmd.pos_sel = PS_ROOT;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_INSERT) begin
            if (sts.full) begin
              cmd.set_fail = 1'b1;
              state_next   = ST_TOP_RD;
            end else begin
              cmd.load_ins = 1'b1;
              cmd.pos_ld   = 1'b1;
              cmd.pos_sel  = PS_INS;
              state_next   = ST_UP;
            end
          end else begin
            if (sts.empty) begin
              cmd.set_fail = 1'b1;
              state_next   = ST_TOP_RD;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_ROOT;
              state_next = ST_RM_ROOT;
            end
          end
        end
      end
      ST_RM_ROOT: begin
        cmd.ld_removed = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RA_LAST;
        state_next     = ST_RM_LAST;
      end
      ST_RM_LAST: begin
        // last item becomes the moving value, sift starts at the root
        cmd.ld_last = 1'b1;
        cmd.pos_ld  = 1'b1;
        cmd.pos_sel = PS_ROOT;
        state_next  = ST_DN;
      end
      ST_UP: begin
        if (sts.pos_root) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_V;
          state_next = ST_TOP_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PARENT;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        // parent moves down only when the new value is strictly greater
        if (sts.v_gt_rd) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WD_RD;
          cmd.pos_ld  = 1'b1;
          cmd.pos_sel = PS_PARENT;
          state_next  = ST_UP;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_V;
          state_next = ST_TOP_RD;
        end
      end
      ST_DN: begin
        if (sts.has_left) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_LEFT;
          state_next = ST_DN_LEFT;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_V;
          state_next = ST_TOP_RD;
        end
      end
      ST_DN_LEFT: begin
        cmd.ld_lval = 1'b1;
        priority if (sts.has_right) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_RIGHT;
          state_next = ST_DN_RIGHT;
        end else if (sts.rd_gt_v) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WD_RD;
          cmd.pos_ld  = 1'b1;
          cmd.pos_sel = PS_LEFT;
          state_next  = ST_DN;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_V;
          state_next = ST_TOP_RD;
        end
      end
      ST_DN_RIGHT: begin
        if (sts.rd_gt_l ? sts.rd_gt_v : sts.l_gt_v) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WD_BEST;
          cmd.pos_ld  = 1'b1;
          cmd.pos_sel = PS_BEST;
          state_next  = ST_DN;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_V;
          state_next = ST_TOP_RD;
        end
      end
      ST_TOP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_ROOT;
        state_next = ST_TOP;
      end
      ST_TOP: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/max_heap_priority_queue_top.sv */
// per item: a refused item only reads the root for the result; an insert climbs
// while it is greater than its parent, a remove moves the last item to the root and
// sifts it down while a child is greater, then the root is read for the result.
// throughput: one item at a time, paced by the heap ram, used for a read or a write
// at a time; a waiting result does not block the next item's accept, only its result.
// reset: clears item count, out_valid and controller; ram not cleared
module max_heap_priority_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [mhpq_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [mhpq_pkg::DATA_W-1:0] removed_value,
  output logic signed [mhpq_pkg::DATA_W-1:0] top_value,
  output logic [mhpq_pkg::COUNT_W-1:0]       count,
  output logic                               is_empty
);
  import mhpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode  (opcode),
    .sts     (sts),
    .cmd     (cmd)
  );

  mhpq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .ok           (ok),
    .removed_value(removed_value),
    .top_value    (top_value),
    .count        (count),
    .is_empty     (is_empty)
  );

`ifndef ASSERT_OFF
  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while one is in progress");

  // a new result appears only as the controller returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while an item is still in progress");

  // ram is never written and read in the same cycle
  a_ram_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("heap ram read and write collide");

  a_refused_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> removed_value == '1)
    else $error("refused item reports a removed value");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> top_value == '1 && count == '0)
    else $error("empty heap reports a top value or a count");
`endif

endmodule
